### rtl/gtbi_pkg.sv
package gtbi_pkg;

  // Fixed-point format of the coordinates.
  localparam int FRACTION_BITS = 20;
  localparam int LON_W         = 29;
  localparam int LAT_W         = 28;

  // Whole-degree widths of the floored coordinates.
  localparam int LON_DEG_W = 9;
  localparam int LAT_DEG_W = 8;

  // Eighth-degree sub-column and row width.
  localparam int SUB_W = 3;

  // Width of the magnitude that feeds the span snapping.
  localparam int SNAP_W = 8;

  // Quotient by twelve as a multiply by 171 and a shift by 11 (exact for 0..255).
  localparam logic [SNAP_W-1:0] RECIP_12     = 8'd171;
  localparam int                RECIP_SHIFT  = 11;
  localparam int                QUOT_W       = 5;
  localparam int                PROD_W       = 2 * SNAP_W;

  // Span codes.
  localparam logic [2:0] SPAN_EIGHTH  = 3'd0;
  localparam logic [2:0] SPAN_QUARTER = 3'd1;
  localparam logic [2:0] SPAN_HALF    = 3'd2;
  localparam logic [2:0] SPAN_ONE     = 3'd3;
  localparam logic [2:0] SPAN_TWO     = 3'd4;
  localparam logic [2:0] SPAN_FOUR    = 3'd5;
  localparam logic [2:0] SPAN_TWELVE  = 3'd6;

  // Latitude band edges in whole degrees.
  localparam logic signed [LAT_DEG_W-1:0] LAT_POLAR    = 8'sd89;
  localparam logic signed [LAT_DEG_W-1:0] LAT_CAP      = 8'sd86;
  localparam logic signed [LAT_DEG_W-1:0] LAT_HIGH     = 8'sd83;
  localparam logic signed [LAT_DEG_W-1:0] LAT_SUBPOLAR = 8'sd76;
  localparam logic signed [LAT_DEG_W-1:0] LAT_MID      = 8'sd62;
  localparam logic signed [LAT_DEG_W-1:0] LAT_TROPIC   = 8'sd22;

  // Westmost tile edge and the index offsets.
  localparam logic signed [LON_DEG_W:0] LON_WEST   = -10'sd180;
  localparam logic [LON_DEG_W-1:0]      LON_OFFSET = 9'd180;
  localparam logic [LAT_DEG_W+1:0]      LAT_OFFSET = 10'd90;

  localparam int INDEX_W = 23;

  typedef struct packed {
    logic signed [LON_DEG_W-1:0] lon_deg;
    logic [SUB_W-1:0]            lon_sub;
    logic signed [LAT_DEG_W-1:0] lat_deg;
    logic [SUB_W-1:0]            row;
    logic [2:0]                  code;
  } dec_t;

  typedef struct packed {
    logic signed [LON_DEG_W-1:0] lon;
    logic signed [LAT_DEG_W-1:0] lat;
    logic [SUB_W-1:0]            column;
    logic [SUB_W-1:0]            row;
    logic [2:0]                  code;
  } tile_t;

endpackage

### rtl/geo_tile_bucket_index_unit.sv
// Geographic tile bucket index unit.
//
// The input channel carries one coordinate pair per item: in_lon_fixed and
// in_lat_fixed, signed degrees with twenty fraction bits. The result channel
// returns one item per input item: the tile's west edge longitude, floored
// latitude, sub-degree column, eighth-degree row, span code and packed index.
// Both channels use valid and stall; an item moves on an edge where valid is
// high and stall is low.
//
// The pipeline has four register stages: decode (floor, fraction, latitude
// band), reciprocal multiply for the twelve-degree snap, snap and clamp, and
// index packing in the output register. One item is taken every cycle while
// out_stall is low.
//
// Each stage holds its own valid bit. When out_stall is high, the output item
// holds still and the stages behind it keep filling until each is occupied;
// in_stall rises only once every stage holds an item. Nothing is dropped or
// repeated. A synchronous reset on rst_n empties all stages.
module geo_tile_bucket_index_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [gtbi_pkg::LON_W-1:0]      in_lon_fixed,
  input  logic signed [gtbi_pkg::LAT_W-1:0]      in_lat_fixed,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [gtbi_pkg::LON_DEG_W-1:0]  out_tile_lon,
  output logic signed [gtbi_pkg::LAT_DEG_W-1:0]  out_tile_lat,
  output logic [gtbi_pkg::SUB_W-1:0]             out_column,
  output logic [gtbi_pkg::SUB_W-1:0]             out_row,
  output logic [2:0]                             out_span_code,
  output logic [gtbi_pkg::INDEX_W-1:0]           out_tile_index
);

  logic            dec_valid;
  logic            dec_stall;
  gtbi_pkg::dec_t  dec;
  logic            snap_valid;
  logic            snap_stall;
  gtbi_pkg::tile_t snap_tile;
  gtbi_pkg::tile_t out_tile;

  // Stage one: split both coordinates and pick the latitude band.
  gtbi_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_valid),
    .i_lon   (in_lon_fixed),
    .i_lat   (in_lat_fixed),
    .o_stall (in_stall),
    .o_valid (dec_valid),
    .o_dec   (dec),
    .i_stall (dec_stall)
  );

  // Stages two and three: snap wide spans, derive the sub-column.
  gtbi_snap u_snap (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (dec_valid),
    .i_dec   (dec),
    .o_stall (dec_stall),
    .o_valid (snap_valid),
    .o_tile  (snap_tile),
    .i_stall (snap_stall)
  );

  // Stage four: pack the index into the output register.
  gtbi_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (snap_valid),
    .i_tile  (snap_tile),
    .o_stall (snap_stall),
    .o_valid (out_valid),
    .o_tile  (out_tile),
    .o_index (out_tile_index),
    .i_stall (out_stall)
  );

  assign out_tile_lon  = out_tile.lon;
  assign out_tile_lat  = out_tile.lat;
  assign out_column    = out_tile.column;
  assign out_row       = out_tile.row;
  assign out_span_code = out_tile.code;

endmodule

### rtl/gtbi_decode.sv
module gtbi_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 i_valid,
  input  logic signed [gtbi_pkg::LON_W-1:0]    i_lon,
  input  logic signed [gtbi_pkg::LAT_W-1:0]    i_lat,
  output logic                                 o_stall,
  output logic                                 o_valid,
  output gtbi_pkg::dec_t                       o_dec,
  input  logic                                 i_stall
);

  logic           valid_r;
  gtbi_pkg::dec_t dec_r;
  gtbi_pkg::dec_t dec_nxt;
  logic           load;

  // Bands are compared on the floored latitude, which is exact because every
  // band edge is a whole degree.
  function automatic logic [2:0] span_of(logic signed [gtbi_pkg::LAT_DEG_W-1:0] lat);
    logic [2:0] code;
    priority if (lat >= gtbi_pkg::LAT_POLAR)     code = gtbi_pkg::SPAN_TWELVE;
    else if (lat >= gtbi_pkg::LAT_CAP)           code = gtbi_pkg::SPAN_FOUR;
    else if (lat >= gtbi_pkg::LAT_HIGH)          code = gtbi_pkg::SPAN_TWO;
    else if (lat >= gtbi_pkg::LAT_SUBPOLAR)      code = gtbi_pkg::SPAN_ONE;
    else if (lat >= gtbi_pkg::LAT_MID)           code = gtbi_pkg::SPAN_HALF;
    else if (lat >= gtbi_pkg::LAT_TROPIC)        code = gtbi_pkg::SPAN_QUARTER;
    else if (lat >= -gtbi_pkg::LAT_TROPIC)       code = gtbi_pkg::SPAN_EIGHTH;
    else if (lat >= -gtbi_pkg::LAT_MID)          code = gtbi_pkg::SPAN_QUARTER;
    else if (lat >= -gtbi_pkg::LAT_SUBPOLAR)     code = gtbi_pkg::SPAN_HALF;
    else if (lat >= -gtbi_pkg::LAT_HIGH)         code = gtbi_pkg::SPAN_ONE;
    else if (lat >= -gtbi_pkg::LAT_CAP)          code = gtbi_pkg::SPAN_TWO;
    else if (lat >= -gtbi_pkg::LAT_POLAR)        code = gtbi_pkg::SPAN_FOUR;
    else                                         code = gtbi_pkg::SPAN_TWELVE;
    return code;
  endfunction

  // An arithmetic shift floors, so the whole degrees are the upper bits and
  // the non-negative fraction the lower bits.
  always_comb begin
    dec_nxt.lon_deg = i_lon[gtbi_pkg::FRACTION_BITS +: gtbi_pkg::LON_DEG_W];
    dec_nxt.lon_sub = i_lon[gtbi_pkg::FRACTION_BITS-1 -: gtbi_pkg::SUB_W];
    dec_nxt.lat_deg = i_lat[gtbi_pkg::FRACTION_BITS +: gtbi_pkg::LAT_DEG_W];
    dec_nxt.row     = i_lat[gtbi_pkg::FRACTION_BITS-1 -: gtbi_pkg::SUB_W];
    dec_nxt.code    = span_of(i_lat[gtbi_pkg::FRACTION_BITS +: gtbi_pkg::LAT_DEG_W]);
  end

  assign o_stall = valid_r && i_stall;
  assign load    = !o_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && i_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_dec   = dec_r;

endmodule

### rtl/gtbi_snap.sv
module gtbi_snap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              i_valid,
  input  gtbi_pkg::dec_t    i_dec,
  output logic              o_stall,
  output logic              o_valid,
  output gtbi_pkg::tile_t   o_tile,
  input  logic              i_stall
);

  // First stage: magnitude to snap and its product with the reciprocal of twelve.
  logic                               va_r;
  gtbi_pkg::dec_t                     deca_r;
  logic [gtbi_pkg::SNAP_W-1:0]        mag_r;
  logic [gtbi_pkg::PROD_W-1:0]        prod_r;
  logic [gtbi_pkg::SNAP_W-1:0]        mag_nxt;
  logic                               stall_a;
  logic                               load_a;

  // Second stage: snapped tile edge and sub-column.
  logic                               vb_r;
  gtbi_pkg::tile_t                    tile_r;
  gtbi_pkg::tile_t                    tile_nxt;
  logic                               load_b;

  logic                               neg;
  logic                               wide;
  logic [gtbi_pkg::QUOT_W-1:0]        quot;
  logic [gtbi_pkg::SNAP_W-1:0]        quot12;
  logic [gtbi_pkg::SNAP_W-1:0]        snap;
  logic [gtbi_pkg::SNAP_W-1:0]        span;
  logic signed [gtbi_pkg::LON_DEG_W:0] west;

  // For a negative longitude the snap works on -(floor+1), which is the
  // bitwise complement of the floored degree.
  assign neg     = i_dec.lon_deg[gtbi_pkg::LON_DEG_W-1];
  assign mag_nxt = neg ? ~i_dec.lon_deg[gtbi_pkg::SNAP_W-1:0]
                       : i_dec.lon_deg[gtbi_pkg::SNAP_W-1:0];

  assign stall_a = va_r && (vb_r && i_stall);
  assign load_a  = !stall_a;
  assign load_b  = !(vb_r && i_stall);
  assign o_stall = stall_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (load_a) begin
        va_r <= i_valid;
      end
      if (load_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a && i_valid) begin
      deca_r <= i_dec;
      mag_r  <= mag_nxt;
      prod_r <= mag_nxt * gtbi_pkg::RECIP_12;
    end
    if (load_b && va_r) begin
      tile_r <= tile_nxt;
    end
  end

  assign quot   = prod_r[gtbi_pkg::RECIP_SHIFT +: gtbi_pkg::QUOT_W];
  assign quot12 = ({3'b000, quot} << 3) + ({3'b000, quot} << 2);

  always_comb begin
    wide = 1'b1;
    unique case (deca_r.code)
      gtbi_pkg::SPAN_TWO: begin
        snap = {mag_r[gtbi_pkg::SNAP_W-1:1], 1'b0};
        span = 8'd2;
      end
      gtbi_pkg::SPAN_FOUR: begin
        snap = {mag_r[gtbi_pkg::SNAP_W-1:2], 2'b00};
        span = 8'd4;
      end
      gtbi_pkg::SPAN_TWELVE: begin
        snap = quot12;
        span = 8'd12;
      end
      default: begin
        wide = 1'b0;
        snap = mag_r;
        span = 8'd0;
      end
    endcase
  end

  // West edge of a wide tile; negative longitudes step one span further west
  // and stop at the antimeridian.
  always_comb begin
    if (deca_r.lon_deg[gtbi_pkg::LON_DEG_W-1]) begin
      west = 10'sd0 - $signed({2'b00, snap}) - $signed({2'b00, span});
      if (west < gtbi_pkg::LON_WEST) begin
        west = gtbi_pkg::LON_WEST;
      end
    end else begin
      west = $signed({2'b00, snap});
    end
  end

  always_comb begin
    tile_nxt.lat  = deca_r.lat_deg;
    tile_nxt.row  = deca_r.row;
    tile_nxt.code = deca_r.code;
    if (wide) begin
      tile_nxt.lon    = west[gtbi_pkg::LON_DEG_W-1:0];
      tile_nxt.column = '0;
    end else begin
      tile_nxt.lon    = deca_r.lon_deg;
      tile_nxt.column = deca_r.lon_sub >> deca_r.code[1:0];
    end
  end

  assign o_valid = vb_r;
  assign o_tile  = tile_r;

endmodule

### rtl/gtbi_pack.sv
module gtbi_pack (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  i_valid,
  input  gtbi_pkg::tile_t                       i_tile,
  output logic                                  o_stall,
  output logic                                  o_valid,
  output gtbi_pkg::tile_t                       o_tile,
  output logic [gtbi_pkg::INDEX_W-1:0]          o_index,
  input  logic                                  i_stall
);

  logic                                valid_r;
  gtbi_pkg::tile_t                     tile_r;
  logic [gtbi_pkg::INDEX_W-1:0]        index_r;
  logic [gtbi_pkg::INDEX_W-1:0]        index_nxt;
  logic [gtbi_pkg::LON_DEG_W-1:0]      lon_bias;
  logic [gtbi_pkg::LAT_DEG_W+1:0]      lat_bias;
  logic                                load;

  // Both biased fields wrap like the packed index does; the latitude term is
  // sign-extended so an out-of-range latitude borrows from the longitude field.
  assign lon_bias  = i_tile.lon + gtbi_pkg::LON_OFFSET;
  assign lat_bias  = {{2{i_tile.lat[gtbi_pkg::LAT_DEG_W-1]}}, i_tile.lat}
                   + gtbi_pkg::LAT_OFFSET;
  assign index_nxt = {lon_bias, 14'd0}
                   + {{7{lat_bias[gtbi_pkg::LAT_DEG_W+1]}}, lat_bias,
                      i_tile.row, i_tile.column};

  assign o_stall = valid_r && i_stall;
  assign load    = !o_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && i_valid) begin
      tile_r  <= i_tile;
      index_r <= index_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_tile  = tile_r;
  assign o_index = index_r;

endmodule

### rtl/gtbi_checker.sv
module gtbi_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [gtbi_pkg::SUB_W-1:0]             out_column,
  input logic [gtbi_pkg::SUB_W-1:0]             out_row,
  input logic [2:0]                             out_span_code,
  input logic [gtbi_pkg::INDEX_W-1:0]           out_tile_index
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tile_index)
                               && $stable(out_span_code))
    else $error("stalled result changed");

  // The input side only stalls when the whole pipeline is backed up.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output was free");

  // Wide spans carry no sub-column.
  a_wide_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_span_code == gtbi_pkg::SPAN_TWO || out_span_code == gtbi_pkg::SPAN_FOUR
                  || out_span_code == gtbi_pkg::SPAN_TWELVE) |-> out_column == '0)
    else $error("column set for a wide span");

  // The low index bits are the row and column.
  a_index_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tile_index[5:0] == {out_row, out_column})
    else $error("index low bits disagree with row and column");

endmodule

bind geo_tile_bucket_index_unit gtbi_checker u_gtbi_checker (.*);
